// File: rtl/keyed_record_table_with_compaction_unit_assert.svh
// Assertion macros for the keyed record table, empty under synthesis.
`ifndef KEYED_RECORD_TABLE_WITH_COMPACTION_UNIT_ASSERT_SVH
`define KEYED_RECORD_TABLE_WITH_COMPACTION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define KTC_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ktc: assertion failed");
// Next-cycle implication.
`define KTC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ktc: assertion failed");
`else
`define KTC_ASSERT_IMPL(name, clk, rst, ante, cons)
`define KTC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// File: rtl/ktc_pkg.sv
// Shared constants, codes and types of the keyed record table.
package ktc_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int KEY_W    = 32;
  localparam int PAY_W    = 64;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 3;
  localparam int HIT_W    = 6;
  localparam int CMP_W    = 7;
  localparam int FILL_W   = 7;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_GET    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_DUP    = 3'd2,
    ST_MISS   = 3'd3,
    ST_BOUNDS = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  // Ring control from the sequencer to the cell chain.
  typedef struct packed {
    logic shift;    // every cell loads from its neighbor
    logic compact;  // tail cell holds, next-to-tail wraps from the head
    logic append;   // tail cell loads the new record
  } ring_ctl_t;

endpackage

// File: rtl/keyed_record_table_with_compaction_unit.sv
// Top level of the keyed record table: a rotating chain of record cells and its sequencer.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready   | func, key, payload, slot
//  out     | output    | out_valid / out_ready | status, hit_index, compare_count,
//          |           |                       | entry_key, entry_payload, fill_level
//
// Each item is accepted in S_IDLE, makes one full rotation of the cell chain past the head
// comparator in S_RUN, and has its result registered in S_DONE.
// The rotation length is set by the chain: every record passes the head cell once.
// Reset clears the state, step, hit flag, entry count and out_valid; the cells need no clearing pass.
// A result stalled on out_ready holds the sequencer in its result cycle; the input side
// takes the next item as soon as the result is registered.
module keyed_record_table_with_compaction_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          func,
  input  logic signed [ktc_pkg::KEY_W-1:0]    key,
  input  logic [ktc_pkg::PAY_W-1:0]           payload,
  input  logic [ktc_pkg::SLOT_W-1:0]          slot,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ktc_pkg::STATUS_W-1:0]        status,
  output logic [ktc_pkg::HIT_W-1:0]           hit_index,
  output logic [ktc_pkg::CMP_W-1:0]           compare_count,
  output logic signed [ktc_pkg::KEY_W-1:0]    entry_key,
  output logic [ktc_pkg::PAY_W-1:0]           entry_payload,
  output logic [ktc_pkg::FILL_W-1:0]          fill_level
);

  localparam int N = ktc_pkg::CAPACITY;

  ktc_pkg::ring_ctl_t             ring;
  logic [ktc_pkg::KEY_W-1:0]      req_key;
  logic [ktc_pkg::PAY_W-1:0]      req_payload;
  logic [ktc_pkg::KEY_W-1:0]      ekey;
  logic [ktc_pkg::KEY_W-1:0]      cell_key  [N];
  logic [ktc_pkg::PAY_W-1:0]      cell_pay  [N];
  logic [ktc_pkg::KEY_W-1:0]      d_key     [N];
  logic [ktc_pkg::PAY_W-1:0]      d_pay     [N];

  assign entry_key = ekey;

  // Sequencer
  ktc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .key           (key),
    .payload       (payload),
    .slot          (slot),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .hit_index     (hit_index),
    .compare_count (compare_count),
    .entry_key     (ekey),
    .entry_payload (entry_payload),
    .fill_level    (fill_level),
    .head_key      (cell_key[0]),
    .head_payload  (cell_pay[0]),
    .ring          (ring),
    .req_key       (req_key),
    .req_payload   (req_payload)
  );

  // Cell chain: each cell takes its upper neighbor, the tail takes the head
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_tail
      // Tail: append the new record, hold while compacting, else wrap the head
      assign d_key[i] = ring.append  ? req_key     :
                        ring.compact ? cell_key[i] : cell_key[0];
      assign d_pay[i] = ring.append  ? req_payload :
                        ring.compact ? cell_pay[i] : cell_pay[0];
    end else if (i == N - 2) begin : g_wrap
      // Next to tail: close the shortened ring while compacting
      assign d_key[i] = ring.compact ? cell_key[0] : cell_key[i+1];
      assign d_pay[i] = ring.compact ? cell_pay[0] : cell_pay[i+1];
    end else begin : g_body
      assign d_key[i] = cell_key[i+1];
      assign d_pay[i] = cell_pay[i+1];
    end

    ktc_cell u_cell (
      .clk       (clk),
      .shift     (ring.shift),
      .d_key     (d_key[i]),
      .d_payload (d_pay[i]),
      .q_key     (cell_key[i]),
      .q_payload (cell_pay[i])
    );
  end

endmodule

// File: rtl/ktc_cell.sv
// One table cell: a record register that loads from its neighbor on shift.
module ktc_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [ktc_pkg::KEY_W-1:0] d_key,
  input  logic [ktc_pkg::PAY_W-1:0] d_payload,
  output logic [ktc_pkg::KEY_W-1:0] q_key,
  output logic [ktc_pkg::PAY_W-1:0] q_payload
);

  // Load the record handed over by the neighbor
  always_ff @(posedge clk) begin
    if (shift) begin
      q_key     <= d_key;
      q_payload <= d_payload;
    end
  end

endmodule

// File: rtl/ktc_ctrl.sv
// Sequencer: runs one ring rotation per item, compares at the head, builds results.
`include "keyed_record_table_with_compaction_unit_assert.svh"

module ktc_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic [ktc_pkg::KEY_W-1:0]    key,
  input  logic [ktc_pkg::PAY_W-1:0]    payload,
  input  logic [ktc_pkg::SLOT_W-1:0]   slot,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ktc_pkg::STATUS_W-1:0] status,
  output logic [ktc_pkg::HIT_W-1:0]    hit_index,
  output logic [ktc_pkg::CMP_W-1:0]    compare_count,
  output logic [ktc_pkg::KEY_W-1:0]    entry_key,
  output logic [ktc_pkg::PAY_W-1:0]    entry_payload,
  output logic [ktc_pkg::FILL_W-1:0]   fill_level,
  input  logic [ktc_pkg::KEY_W-1:0]    head_key,
  input  logic [ktc_pkg::PAY_W-1:0]    head_payload,
  output ktc_pkg::ring_ctl_t           ring,
  output logic [ktc_pkg::KEY_W-1:0]    req_key,
  output logic [ktc_pkg::PAY_W-1:0]    req_payload
);

  ktc_pkg::state_t              state;
  ktc_pkg::state_t              state_next;
  ktc_pkg::op_t                 op;
  logic [ktc_pkg::SLOT_W-1:0]   slot_r;
  logic [ktc_pkg::IDX_W-1:0]    step;
  logic [ktc_pkg::IDX_W-1:0]    hit_pos;
  logic [ktc_pkg::CNT_W-1:0]    count;
  logic [ktc_pkg::CNT_W-1:0]    count_next;
  logic                         found;
  logic [ktc_pkg::KEY_W-1:0]    get_key;
  logic [ktc_pkg::PAY_W-1:0]    get_payload;

  logic                         accept;
  logic                         running;
  logic                         last_step;
  logic                         step_live;
  logic                         head_match;
  logic                         not_full;
  logic                         in_bounds;
  logic                         out_load;
  logic [ktc_pkg::CNT_W-1:0]    hit_cnt;

  ktc_pkg::status_t             res_status;
  logic [ktc_pkg::HIT_W-1:0]    res_hit;
  logic [ktc_pkg::CMP_W-1:0]    res_cmp;
  logic [ktc_pkg::KEY_W-1:0]    res_ekey;
  logic [ktc_pkg::PAY_W-1:0]    res_epay;

  // Handshake and step decode
  assign in_ready   = (state == ktc_pkg::S_IDLE);
  assign accept     = in_valid && in_ready;
  assign running    = (state == ktc_pkg::S_RUN);
  assign last_step  = (step == ktc_pkg::IDX_W'(ktc_pkg::CAPACITY - 1));
  assign step_live  = (ktc_pkg::CNT_W'(step) < count);
  assign head_match = running && step_live && !found && (op != ktc_pkg::OP_GET) &&
                      (head_key == req_key);
  assign not_full   = (count < ktc_pkg::CNT_W'(ktc_pkg::CAPACITY));
  assign in_bounds  = (32'(slot_r) < 32'(count));
  assign out_load   = (state == ktc_pkg::S_DONE) && (!out_valid || out_ready);
  assign hit_cnt    = ktc_pkg::CNT_W'(hit_pos) + ktc_pkg::CNT_W'(1);

  // Drive the ring: rotate while running, compact after a remove hit, append at the fill point
  assign ring.shift   = running;
  assign ring.compact = running && found && (op == ktc_pkg::OP_REMOVE);
  assign ring.append  = running && (op == ktc_pkg::OP_ADD) && !found && not_full &&
                        (ktc_pkg::CNT_W'(step) == count);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ktc_pkg::S_IDLE: begin
        if (accept) state_next = ktc_pkg::S_RUN;
      end
      ktc_pkg::S_RUN: begin
        if (last_step) state_next = ktc_pkg::S_DONE;
      end
      ktc_pkg::S_DONE: begin
        if (out_load) state_next = ktc_pkg::S_IDLE;
      end
      default: state_next = ktc_pkg::S_IDLE;
    endcase
  end

  // Result of the finished rotation
  always_comb begin
    res_status = ktc_pkg::ST_OK;
    res_hit    = '0;
    res_cmp    = '0;
    res_ekey   = '0;
    res_epay   = '0;
    count_next = count;
    unique case (op)
      ktc_pkg::OP_ADD: begin
        if (!not_full) begin
          res_status = ktc_pkg::ST_FULL;
        end else if (found) begin
          res_status = ktc_pkg::ST_DUP;
        end else begin
          count_next = count + ktc_pkg::CNT_W'(1);
        end
      end
      ktc_pkg::OP_FIND: begin
        if (found) begin
          res_hit = ktc_pkg::HIT_W'(hit_pos);
          res_cmp = ktc_pkg::CMP_W'(hit_cnt);
        end else begin
          res_status = ktc_pkg::ST_MISS;
          res_cmp    = ktc_pkg::CMP_W'(count);
        end
      end
      ktc_pkg::OP_REMOVE: begin
        if (found) begin
          count_next = count - ktc_pkg::CNT_W'(1);
        end else begin
          res_status = ktc_pkg::ST_MISS;
        end
      end
      ktc_pkg::OP_GET: begin
        if (in_bounds) begin
          res_ekey = get_key;
          res_epay = get_payload;
        end else begin
          res_status = ktc_pkg::ST_BOUNDS;
        end
      end
      default: res_status = ktc_pkg::ST_OK;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ktc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: step, hit flag, entry count, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      found     <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        step  <= '0;
        found <= 1'b0;
      end else if (running) begin
        step <= step + ktc_pkg::IDX_W'(1);
        if (head_match) found <= 1'b1;
      end
      if (out_load) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request, capture and output payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op          <= ktc_pkg::op_t'(func);
      req_key     <= key;
      req_payload <= payload;
      slot_r      <= slot;
    end
    if (head_match) hit_pos <= step;
    if (running && (32'(step) == 32'(slot_r))) begin
      get_key     <= head_key;
      get_payload <= head_payload;
    end
    if (out_load) begin
      status        <= res_status;
      hit_index     <= res_hit;
      compare_count <= res_cmp;
      entry_key     <= res_ekey;
      entry_payload <= res_epay;
      fill_level    <= ktc_pkg::FILL_W'(count_next);
    end
  end

  `KTC_ASSERT_IMPL(a_count_in_range, clk, rst, 1'b1, count <= ktc_pkg::CNT_W'(ktc_pkg::CAPACITY))
  `KTC_ASSERT_IMPL(a_ring_exclusive, clk, rst, ring.compact, !ring.append)
  `KTC_ASSERT_NEXT(a_accept_starts, clk, rst, accept, running && (step == '0) && !found)
  `KTC_ASSERT_NEXT(a_count_on_load, clk, rst, !out_load, $stable(count))

endmodule

// File: sim/keyed_record_table_with_compaction_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the keyed record table: directed and phased random traffic.
module keyed_record_table_with_compaction_unit_test;
  import ktc_pkg::*;

  localparam int     RANDOM_ITEMS = 450;
  localparam int     ITEM_CYCLES  = CAPACITY + 2;
  localparam int     REPORT_MAX   = 10;
  localparam longint RUN_LIMIT_NS = 6_000_000;

  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIX
  } phase_t;

  typedef struct packed {
    op_t               func;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
    logic [SLOT_W-1:0] slot;
  } table_req_t;

  typedef struct packed {
    status_t           status;
    logic [HIT_W-1:0]  hit_index;
    logic [CMP_W-1:0]  compare_count;
    logic [KEY_W-1:0]  entry_key;
    logic [PAY_W-1:0]  entry_payload;
    logic [FILL_W-1:0] fill_level;
  } table_result_t;

  logic                     clk;
  logic                     rst           = 1'b1;
  logic                     in_valid      = 1'b0;
  logic                     in_ready;
  logic [1:0]               func          = OP_FIND;
  logic signed [KEY_W-1:0]  key           = '0;
  logic [PAY_W-1:0]         payload       = '0;
  logic [SLOT_W-1:0]        slot          = '0;
  logic                     out_valid;
  logic                     out_ready     = 1'b0;
  logic [STATUS_W-1:0]      status;
  logic [HIT_W-1:0]         hit_index;
  logic [CMP_W-1:0]         compare_count;
  logic signed [KEY_W-1:0]  entry_key;
  logic [PAY_W-1:0]         entry_payload;
  logic [FILL_W-1:0]        fill_level;

  // Predicted table contents.
  logic [KEY_W-1:0]  shadow_key [CAPACITY];
  logic [PAY_W-1:0]  shadow_pay [CAPACITY];
  int                shadow_count = 0;

  // Keys the generator believes are present, in table order.
  logic [KEY_W-1:0]  gen_keys [$];

  table_req_t        pending_items [$];
  table_result_t     table_expect [$];
  table_req_t        cur_item;
  table_result_t     want_result;
  table_result_t     got_result;

  int                send_gap    = 0;
  int                burst_left  = 1;
  int                ready_run   = 0;
  int                ready_stall = 0;
  int                fail_count  = 0;
  int                result_count = 0;

  keyed_record_table_with_compaction_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .key           (key),
    .payload       (payload),
    .slot          (slot),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .hit_index     (hit_index),
    .compare_count (compare_count),
    .entry_key     (entry_key),
    .entry_payload (entry_payload),
    .fill_level    (fill_level)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one operation to the predicted table and return its result.
  function automatic table_result_t table_apply(table_req_t req);
    table_result_t res;
    int            pos;
    int            cmps;
    bit            found;
    res   = '0;
    pos   = 0;
    cmps  = 0;
    found = 1'b0;
    res.status = ST_OK;
    for (int i = 0; i < shadow_count && !found; i++) begin
      cmps = i + 1;
      if (shadow_key[i] == req.key) begin
        found = 1'b1;
        pos   = i;
      end
    end
    case (req.func)
      OP_ADD: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (found) begin
          res.status = ST_DUP;
        end else begin
          shadow_key[shadow_count] = req.key;
          shadow_pay[shadow_count] = req.payload;
          shadow_count++;
        end
      end
      OP_FIND: begin
        res.compare_count = cmps[CMP_W-1:0];
        if (found) begin
          res.hit_index = pos[HIT_W-1:0];
        end else begin
          res.status = ST_MISS;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          // close the gap left by the removed record
          for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_key[i] = shadow_key[i + 1];
            shadow_pay[i] = shadow_pay[i + 1];
          end
          shadow_count--;
        end else begin
          res.status = ST_MISS;
        end
      end
      default: begin
        if (int'(req.slot) >= shadow_count) begin
          res.status = ST_BOUNDS;
        end else begin
          res.entry_key     = shadow_key[req.slot];
          res.entry_payload = shadow_pay[req.slot];
        end
      end
    endcase
    res.fill_level = shadow_count[FILL_W-1:0];
    return res;
  endfunction

  // Queue one item and track which keys it leaves in the table.
  task automatic queue_item(op_t f, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
                            logic [SLOT_W-1:0] s);
    table_req_t req;
    int         idx;
    req.func    = f;
    req.key     = k;
    req.payload = p;
    req.slot    = s;
    pending_items.push_back(req);
    idx = -1;
    foreach (gen_keys[i]) begin
      if (idx < 0 && gen_keys[i] == k) idx = i;
    end
    if (f == OP_ADD && idx < 0 && gen_keys.size() < CAPACITY) begin
      gen_keys.push_back(k);
    end else if (f == OP_REMOVE && idx >= 0) begin
      gen_keys.delete(idx);
    end
  endtask

  // Draw a key: small clustered values, extremes, or full range.
  function automatic logic [KEY_W-1:0] any_key();
    int roll;
    int v;
    roll = $urandom_range(0, 7);
    v    = $urandom_range(0, 31);
    case (roll)
      0, 1: return v - 16;
      2: begin
        case (v % 4)
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] held_key();
    if (gen_keys.size() == 0) return any_key();
    return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
  endfunction

  function automatic logic [PAY_W-1:0] any_payload();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // Mostly slots near the fill level, sometimes anywhere.
  function automatic logic [SLOT_W-1:0] any_slot();
    int top;
    top = (gen_keys.size() > CAPACITY - 1) ? CAPACITY - 1 : gen_keys.size();
    if ($urandom_range(0, 3) == 0) return SLOT_W'($urandom_range(0, CAPACITY - 1));
    return SLOT_W'($urandom_range(0, top));
  endfunction

  // Queue one random item weighted for the current phase.
  task automatic queue_random_item(phase_t mode);
    int  roll;
    int  fresh_pct;
    op_t f;
    roll = $urandom_range(0, 99);
    case (mode)
      PH_FILL: begin
        f = (roll < 65) ? OP_ADD : (roll < 80) ? OP_FIND : (roll < 85) ? OP_REMOVE : OP_GET;
        fresh_pct = 85;
      end
      PH_DRAIN: begin
        f = (roll < 55) ? OP_REMOVE : (roll < 75) ? OP_FIND : (roll < 85) ? OP_ADD : OP_GET;
        fresh_pct = 20;
      end
      default: begin
        f = op_t'(roll % 4);
        fresh_pct = 40;
      end
    endcase
    queue_item(f, ($urandom_range(0, 99) < fresh_pct) ? any_key() : held_key(),
               any_payload(), any_slot());
  endtask

  // Driver: present items from the queue in bursts, predict each one on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        table_expect.push_back(table_apply(cur_item));
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        cur_item = pending_items.pop_front();
        func     <= cur_item.func;
        key      <= cur_item.key;
        payload  <= cur_item.payload;
        slot     <= cur_item.slot;
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_gap = $urandom_range(0, 3);
            5, 6, 7:       send_gap = $urandom_range(4, 20);
            8:             send_gap = 0;
            default:       send_gap = $urandom_range(30, 90);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction, drive stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_result.status        = status_t'(status);
        got_result.hit_index     = hit_index;
        got_result.compare_count = compare_count;
        got_result.entry_key     = entry_key;
        got_result.entry_payload = entry_payload;
        got_result.fill_level    = fill_level;
        if (table_expect.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("result %0d arrived with no prediction pending", result_count);
          end
        end else begin
          want_result = table_expect.pop_front();
          if (got_result !== want_result) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("result %0d mismatch: status %0d/%0d hit %0d/%0d cmp %0d/%0d",
                       result_count, want_result.status, got_result.status,
                       want_result.hit_index, got_result.hit_index,
                       want_result.compare_count, got_result.compare_count);
              $display("  key %h/%h payload %h/%h fill %0d/%0d (expected/actual)",
                       want_result.entry_key, got_result.entry_key,
                       want_result.entry_payload, got_result.entry_payload,
                       want_result.fill_level, got_result.fill_level);
            end
          end
        end
        result_count++;
      end
      // alternate ready runs and stall runs of random length
      if (ready_run > 0) begin
        ready_run--;
        out_ready <= 1'b1;
      end else if (ready_stall > 0) begin
        ready_stall--;
        out_ready <= 1'b0;
      end else begin
        ready_run   = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 600)
                                                  : $urandom_range(1, 40);
        ready_stall = $urandom_range(0, 40);
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int     random_count;
    int     extra;
    phase_t mode;

    // directed: empty table, extremes, duplicates, compaction, bounds
    queue_item(OP_FIND,   '0,      '0, '0);
    queue_item(OP_REMOVE, KEY_MAX, '0, '0);
    queue_item(OP_GET,    '0,      '1, 6'd0);
    queue_item(OP_ADD,    KEY_MIN, '1, '1);
    queue_item(OP_ADD,    KEY_MAX, '0, '0);
    queue_item(OP_ADD,    '0,      64'h0123_4567_89AB_CDEF, 6'd21);
    queue_item(OP_ADD,    KEY_MAX, 64'hFFFF_0000_FFFF_0000, '0);
    queue_item(OP_FIND,   KEY_MIN, '0, '0);
    queue_item(OP_FIND,   '0,      '0, '0);
    queue_item(OP_FIND,   '1,      '1, '1);
    queue_item(OP_GET,    '0,      '0, 6'd1);
    queue_item(OP_GET,    '0,      '0, 6'd63);
    queue_item(OP_GET,    '0,      '0, 6'd3);
    queue_item(OP_REMOVE, KEY_MIN, '0, '0);
    queue_item(OP_GET,    '0,      '0, 6'd0);
    queue_item(OP_REMOVE, 32'h1234_5678, '0, '0);
    queue_item(OP_REMOVE, '0,      '0, '0);
    queue_item(OP_GET,    '0,      '0, 6'd0);
    queue_item(OP_REMOVE, KEY_MAX, '0, '0);
    queue_item(OP_FIND,   KEY_MAX, '0, '0);
    queue_item(OP_ADD,    32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 6'h2A);
    queue_item(OP_ADD,    32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 6'h15);
    queue_item(OP_FIND,   32'hAAAA_AAAA, '0, '0);
    queue_item(OP_GET,    '0,      '0, 6'd1);

    // random: fill to capacity, drain to empty, mixed traffic
    random_count = 0;
    mode = PH_FILL;
    while (random_count < RANDOM_ITEMS) begin
      extra = (mode == PH_MIX) ? $urandom_range(20, 60) : $urandom_range(4, 20);
      while (random_count < RANDOM_ITEMS && extra > 0) begin
        queue_random_item(mode);
        random_count++;
        if (mode == PH_MIX || (mode == PH_FILL && gen_keys.size() == CAPACITY) ||
            (mode == PH_DRAIN && gen_keys.size() == 0)) begin
          extra--;
        end
      end
      mode = phase_t'($urandom_range(0, 2));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait for every item to be accepted and every result to arrive
    while (pending_items.size() != 0 || in_valid || table_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (2 * ITEM_CYCLES) @(posedge clk);

    if (fail_count == 0 && table_expect.size() == 0) begin
      $display("keyed_record_table_with_compaction_unit regression: pass");
    end else begin
      $display("keyed_record_table_with_compaction_unit regression: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("keyed_record_table_with_compaction_unit regression: fail");
    $finish;
  end

endmodule

// File: keyed_record_table_with_compaction_unit.f
+incdir+rtl
rtl/ktc_pkg.sv
rtl/ktc_cell.sv
rtl/ktc_ctrl.sv
rtl/keyed_record_table_with_compaction_unit.sv
sim/keyed_record_table_with_compaction_unit_test.sv
